[rtl/sca_pkg.sv]
// shared types and constants of the strip cluster accumulator
// no dependencies
`default_nettype none

package sca_pkg;

	localparam int QB         = 18;
	localparam int DIV_CNT_W  = $clog2(QB);
	localparam int REM_W      = 17;
	localparam logic [21:0] CHARGE_MAX   = 22'h3FFFFF;
	localparam logic [17:0] CENTROID_MAX = 18'h3FFFF;

	localparam logic [3:0] REG_SEED_SIGMA  = 4'd0;
	localparam logic [3:0] REG_HIT_SIGMA   = 4'd1;
	localparam logic [3:0] REG_CHAN_LIMIT  = 4'd2;
	localparam logic [3:0] REG_SAT_LEVEL   = 4'd3;

	localparam logic [4:0]  SEED_SIGMA_RST = 5'd10;
	localparam logic [4:0]  HIT_SIGMA_RST  = 5'd5;
	localparam logic [9:0]  CHAN_LIMIT_RST = 10'd127;
	localparam logic [11:0] SAT_LEVEL_RST  = 12'd4095;

	typedef struct packed {
		logic [4:0]  seed_sigma;
		logic [4:0]  hit_sigma;
		logic [9:0]  channel_limit;
		logic [11:0] saturation_level;
	} cfg_t;

	typedef struct packed {
		logic ld_strip;
		logic upd;
		logic mul0;
		logic mul1;
		logic sum;
		logic chk;
		logic div_step;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic last;
		logic out_room;
	} dp_stat_t;

endpackage

`default_nettype wire

[rtl/sca_cfg.sv]
// configuration register file of the strip cluster accumulator
// depends on sca_pkg
`default_nettype none

module sca_cfg (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              cfg_valid,
	output logic             cfg_ready,
	input  wire  [3:0]       cfg_index,
	input  wire  [11:0]      cfg_data,
	output sca_pkg::cfg_t    cfg
);
	import sca_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.seed_sigma       <= SEED_SIGMA_RST;
			cfg_q.hit_sigma        <= HIT_SIGMA_RST;
			cfg_q.channel_limit    <= CHAN_LIMIT_RST;
			cfg_q.saturation_level <= SAT_LEVEL_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SEED_SIGMA: cfg_q.seed_sigma       <= cfg_data[4:0];
				REG_HIT_SIGMA:  cfg_q.hit_sigma        <= cfg_data[4:0];
				REG_CHAN_LIMIT: cfg_q.channel_limit    <= cfg_data[9:0];
				REG_SAT_LEVEL:  cfg_q.saturation_level <= cfg_data;
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/sca_ctrl.sv]
// sequencer of the strip cluster accumulator: strip update, centroid steps, output load
// depends on sca_pkg
`default_nettype none

module sca_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	input  sca_pkg::dp_stat_t   stat,
	output sca_pkg::dp_cmd_t    cmd
);
	import sca_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_STRIP = 8'b0000_0010,
		S_MUL0  = 8'b0000_0100,
		S_MUL1  = 8'b0000_1000,
		S_SUM   = 8'b0001_0000,
		S_CHK   = 8'b0010_0000,
		S_DIV   = 8'b0100_0000,
		S_LOAD  = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic [DIV_CNT_W-1:0] cnt_q;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.ld_strip = 1'b1;
					state_d      = S_STRIP;
				end
			end
			S_STRIP: begin
				cmd.upd = 1'b1;
				state_d = stat.last ? S_MUL0 : S_IDLE;
			end
			S_MUL0: begin
				cmd.mul0 = 1'b1;
				state_d  = S_MUL1;
			end
			S_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = S_SUM;
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				state_d = S_CHK;
			end
			S_CHK: begin
				cmd.chk = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == DIV_CNT_W'(QB - 1))
					state_d = S_LOAD;
			end
			S_LOAD: begin
				if (stat.out_room) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.chk)
				cnt_q <= '0;
			else if (cmd.div_step)
				cnt_q <= cnt_q + 1'b1;
		end
	end

endmodule

`default_nettype wire

[rtl/sca_dp.sv]
// datapath of the strip cluster accumulator: strip classification, cluster sums,
// shared centroid multiplier, restoring divider and output register; depends on sca_pkg
`default_nettype none

module sca_dp #(
	parameter  int MAX_STRIPS   = 64,
	parameter  int CHANNEL_BITS = 10,
	localparam int CNT_W        = $clog2(MAX_STRIPS + 1)
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  sca_pkg::cfg_t           cfg,
	input  sca_pkg::dp_cmd_t        cmd,
	output sca_pkg::dp_stat_t       stat,
	input  wire  [CHANNEL_BITS-1:0] channel,
	input  wire  [11:0]             adc,
	input  wire  [15:0]             ped_mean,
	input  wire  [15:0]             ped_sigma,
	input  wire                     last_strip,
	output logic                    out_valid,
	input  wire                     out_stall,
	output logic [CNT_W-1:0]        strip_count,
	output logic [CNT_W-1:0]        seed_count,
	output logic [CNT_W-1:0]        hit_count,
	output logic [CNT_W-1:0]        miss_count,
	output logic [9:0]              peak_channel,
	output logic [15:0]             peak_signal,
	output logic [21:0]             cluster_charge,
	output logic [17:0]             centroid,
	output logic                    centroid_valid,
	output logic                    golden_gate,
	output logic                    saturated
);
	import sca_pkg::*;

	localparam int CB     = CHANNEL_BITS;
	localparam int CW     = (CB > 10) ? CB : 10;
	localparam int PROD_W = CB + 19;
	localparam int NUM_W  = PROD_W + 9;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		return (c < CNT_W'(MAX_STRIPS)) ? c + 1'b1 : c;
	endfunction

	// strip input stage
	logic [CB-1:0]      ch_s1;
	logic [11:0]        adc_s1;
	logic [15:0]        ps_s1;
	logic signed [17:0] sig_s1;
	logic               rng_s1;
	logic               last_s1;

	always_ff @(posedge clk) begin
		if (cmd.ld_strip) begin
			ch_s1   <= channel;
			adc_s1  <= adc;
			ps_s1   <= ped_sigma;
			sig_s1  <= $signed({2'b00, adc, 4'b0000}) - $signed({2'b00, ped_mean});
			rng_s1  <= (CW'(channel) <= CW'(cfg.channel_limit));
			last_s1 <= last_strip;
		end
	end

	// cluster state
	logic [CNT_W-1:0]   strip_cnt_q, seed_cnt_q, hit_cnt_q, miss_cnt_q;
	logic [21:0]        charge_q;
	logic [15:0]        peak_q;
	logic [CB-1:0]      peak_chan_q;
	logic signed [17:0] prev_sig_q;
	logic [CB-1:0]      prev_ch_q;
	logic signed [17:0] left_sig_q, right_sig_q;
	logic [CB-1:0]      left_ch_q, right_ch_q;
	logic               pending_q;
	logic [CB-1:0]      lseed_ch_q;
	logic               lseed_vld_q;
	logic               gap_q, sat_q;

	// classification
	logic [20:0]        seed_thr, hit_thr;
	logic signed [21:0] sig_x;
	logic               sig_pos, is_seed, is_hit, peak_gt;
	logic [22:0]        chg_sum;
	logic [CB:0]        lseed_nxt;

	assign seed_thr  = cfg.seed_sigma * ps_s1;
	assign hit_thr   = cfg.hit_sigma * ps_s1;
	assign sig_x     = {{4{sig_s1[17]}}, sig_s1};
	assign sig_pos   = !sig_s1[17] && (sig_s1 != '0);
	assign is_seed   = (ps_s1 == '0) ? sig_pos : (sig_x > $signed({1'b0, seed_thr}));
	assign is_hit    = !is_seed &&
	                   ((ps_s1 == '0) ? sig_pos : (sig_x > $signed({1'b0, hit_thr})));
	assign peak_gt   = sig_s1 > $signed({2'b00, peak_q});
	assign chg_sum   = {1'b0, charge_q} + {6'b0, sig_s1[16:0]};
	assign lseed_nxt = {1'b0, lseed_ch_q} + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strip_cnt_q <= '0;
			seed_cnt_q  <= '0;
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
			charge_q    <= '0;
			peak_q      <= '0;
			peak_chan_q <= '0;
			prev_sig_q  <= '0;
			prev_ch_q   <= '0;
			left_sig_q  <= '0;
			left_ch_q   <= '0;
			right_sig_q <= '0;
			right_ch_q  <= '0;
			pending_q   <= 1'b0;
			lseed_ch_q  <= '0;
			lseed_vld_q <= 1'b0;
			gap_q       <= 1'b0;
			sat_q       <= 1'b0;
		end else if (cmd.out_load) begin
			strip_cnt_q <= '0;
			seed_cnt_q  <= '0;
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
			charge_q    <= '0;
			peak_q      <= '0;
			peak_chan_q <= '0;
			prev_sig_q  <= '0;
			prev_ch_q   <= '0;
			left_sig_q  <= '0;
			left_ch_q   <= '0;
			right_sig_q <= '0;
			right_ch_q  <= '0;
			pending_q   <= 1'b0;
			lseed_ch_q  <= '0;
			lseed_vld_q <= 1'b0;
			gap_q       <= 1'b0;
			sat_q       <= 1'b0;
		end else if (cmd.upd && rng_s1) begin
			if (is_seed)
				seed_cnt_q <= sat_inc(seed_cnt_q);
			else if (is_hit)
				hit_cnt_q <= sat_inc(hit_cnt_q);
			else
				miss_cnt_q <= sat_inc(miss_cnt_q);
			if (is_seed || is_hit)
				charge_q <= chg_sum[22] ? CHARGE_MAX : chg_sum[21:0];
			if (adc_s1 >= cfg.saturation_level)
				sat_q <= 1'b1;
			if (is_seed) begin
				if (lseed_vld_q && (lseed_nxt != {1'b0, ch_s1}))
					gap_q <= 1'b1;
				lseed_ch_q  <= ch_s1;
				lseed_vld_q <= 1'b1;
			end
			if (peak_gt) begin
				peak_q      <= sig_s1[15:0];
				peak_chan_q <= ch_s1;
				left_sig_q  <= (strip_cnt_q != '0) ? prev_sig_q : '0;
				left_ch_q   <= (strip_cnt_q != '0) ? prev_ch_q : '0;
				right_sig_q <= '0;
				right_ch_q  <= '0;
				pending_q   <= 1'b1;
			end else if (pending_q) begin
				right_sig_q <= sig_s1;
				right_ch_q  <= ch_s1;
				pending_q   <= 1'b0;
			end
			prev_sig_q  <= sig_s1;
			prev_ch_q   <= ch_s1;
			strip_cnt_q <= sat_inc(strip_cnt_q);
		end
	end

	// centroid: larger neighbour, shared multiplier, sum, divide
	logic signed [17:0]       ns;
	logic [CB-1:0]            nch;
	logic [CB-1:0]            mul_a;
	logic signed [17:0]       mul_b;
	logic signed [PROD_W-1:0] mul_p;
	logic signed [PROD_W-1:0] prod_q, acc_q;
	logic signed [NUM_W-1:0]  num_q;
	logic signed [18:0]       den_q;
	logic [NUM_W-1:0]         num_u;
	logic [REM_W-1:0]         den_u;
	logic [REM_W-1:0]         rem_q;
	logic [QB-1:0]            quo_q;
	logic [REM_W:0]           trial;
	logic                     cval_q, pos_q, ovf_q;

	assign ns    = (left_sig_q < right_sig_q) ? right_sig_q : left_sig_q;
	assign nch   = (left_sig_q < right_sig_q) ? right_ch_q : left_ch_q;
	assign mul_a = cmd.mul1 ? nch : peak_chan_q;
	assign mul_b = cmd.mul1 ? ns : $signed({2'b00, peak_q});
	assign mul_p = $signed({1'b0, mul_a}) * mul_b;
	assign num_u = $unsigned(num_q);
	assign den_u = den_q[REM_W-1:0];
	assign trial = {rem_q, quo_q[QB-1]};

	always_ff @(posedge clk) begin
		if (cmd.mul0 || cmd.mul1)
			prod_q <= mul_p;
		if (cmd.mul1)
			acc_q <= prod_q;
		if (cmd.sum) begin
			num_q <= (NUM_W'(acc_q) + NUM_W'(prod_q)) <<< 8;
			den_q <= $signed({3'b000, peak_q}) + $signed({ns[17], ns});
		end
		if (cmd.chk) begin
			cval_q <= (peak_q != '0) && !den_q[18] && (den_q != '0);
			pos_q  <= !num_q[NUM_W-1] && (num_q != '0);
			ovf_q  <= (num_u >> QB) >= NUM_W'(den_u);
			rem_q  <= REM_W'(num_u >> QB);
			quo_q  <= num_u[QB-1:0];
		end else if (cmd.div_step) begin
			if (trial >= {1'b0, den_u}) begin
				rem_q <= REM_W'(trial - {1'b0, den_u});
				quo_q <= {quo_q[QB-2:0], 1'b1};
			end else begin
				rem_q <= trial[REM_W-1:0];
				quo_q <= {quo_q[QB-2:0], 1'b0};
			end
		end
	end

	// output register
	logic out_valid_q;

	assign out_valid     = out_valid_q;
	assign stat.last     = last_s1;
	assign stat.out_room = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			strip_count    <= strip_cnt_q;
			seed_count     <= seed_cnt_q;
			hit_count      <= hit_cnt_q;
			miss_count     <= miss_cnt_q;
			peak_channel   <= 10'(peak_chan_q);
			peak_signal    <= peak_q;
			cluster_charge <= charge_q;
			centroid       <= !(cval_q && pos_q) ? '0 : (ovf_q ? CENTROID_MAX : quo_q);
			centroid_valid <= cval_q;
			golden_gate    <= gap_q && (strip_cnt_q >= CNT_W'(3));
			saturated      <= sat_q;
		end
	end

endmodule

`default_nettype wire

[rtl/strip_cluster_accumulator.sv]
// top level of the strip cluster accumulator: config registers, sequencer, datapath
// depends on sca_pkg, sca_cfg, sca_ctrl, sca_dp
//
// channel  direction  handshake               word
// in       input      in_valid / in_stall     one strip
// out      output     out_valid / out_stall   one cluster summary
// cfg      input      cfg_valid / cfg_ready   register index and data
//
// a strip is captured, then classified and its cluster sums are updated
// the last strip then adds 2 shared multiplier passes, sum, range check,
// then the one-bit-a-step restoring divider, then the output load
// the output register lets new strips in while a summary waits on out_stall;
// a second summary waits in the load step until the register is free
// reset clears all cluster state and the config registers to their defaults
`default_nettype none

module strip_cluster_accumulator #(
	parameter  int MAX_STRIPS   = 64,
	parameter  int CHANNEL_BITS = 10,
	localparam int CNT_W        = $clog2(MAX_STRIPS + 1)
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     cfg_valid,
	output logic                    cfg_ready,
	input  wire  [3:0]              cfg_index,
	input  wire  [11:0]             cfg_data,
	input  wire                     in_valid,
	output logic                    in_stall,
	input  wire  [CHANNEL_BITS-1:0] channel,
	input  wire  [11:0]             adc,
	input  wire  [15:0]             ped_mean,
	input  wire  [15:0]             ped_sigma,
	input  wire                     last_strip,
	output logic                    out_valid,
	input  wire                     out_stall,
	output logic [CNT_W-1:0]        strip_count,
	output logic [CNT_W-1:0]        seed_count,
	output logic [CNT_W-1:0]        hit_count,
	output logic [CNT_W-1:0]        miss_count,
	output logic [9:0]              peak_channel,
	output logic [15:0]             peak_signal,
	output logic [21:0]             cluster_charge,
	output logic [17:0]             centroid,
	output logic                    centroid_valid,
	output logic                    golden_gate,
	output logic                    saturated
);
	import sca_pkg::*;

	cfg_t     cfg;
	dp_cmd_t  cmd;
	dp_stat_t stat;

	sca_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sca_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	sca_dp #(
		.MAX_STRIPS   (MAX_STRIPS),
		.CHANNEL_BITS (CHANNEL_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.cmd            (cmd),
		.stat           (stat),
		.channel        (channel),
		.adc            (adc),
		.ped_mean       (ped_mean),
		.ped_sigma      (ped_sigma),
		.last_strip     (last_strip),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.strip_count    (strip_count),
		.seed_count     (seed_count),
		.hit_count      (hit_count),
		.miss_count     (miss_count),
		.peak_channel   (peak_channel),
		.peak_signal    (peak_signal),
		.cluster_charge (cluster_charge),
		.centroid       (centroid),
		.centroid_valid (centroid_valid),
		.golden_gate    (golden_gate),
		.saturated      (saturated)
	);

	a_one_strip_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("strip accepted while previous strip still in work");

	a_centroid_zero_if_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !centroid_valid) |-> (centroid == '0))
		else $error("centroid nonzero without a valid denominator");

	a_counts_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((seed_count <= strip_count) && (hit_count <= strip_count)
		               && (miss_count <= strip_count)))
		else $error("class count above strip count");

	a_gate_needs_two_seeds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && golden_gate) |-> (seed_count >= CNT_W'(2)))
		else $error("golden gate flagged with fewer than two seeds");

endmodule

`default_nettype wire

[tb/sv/sca_checker.sv]
// cluster summary checker for the strip cluster accumulator: follows register writes and
// accepted strips, predicts every summary word and compares it field by field on the output
// depends on sca_pkg
module sca_checker (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_valid,
	input  wire         cfg_ready,
	input  wire  [3:0]  cfg_index,
	input  wire  [11:0] cfg_data,
	input  wire         in_valid,
	input  wire         in_stall,
	input  wire  [9:0]  channel,
	input  wire  [11:0] adc,
	input  wire  [15:0] ped_mean,
	input  wire  [15:0] ped_sigma,
	input  wire         last_strip,
	input  wire         out_valid,
	input  wire         out_stall,
	input  wire  [6:0]  strip_count,
	input  wire  [6:0]  seed_count,
	input  wire  [6:0]  hit_count,
	input  wire  [6:0]  miss_count,
	input  wire  [9:0]  peak_channel,
	input  wire  [15:0] peak_signal,
	input  wire  [21:0] cluster_charge,
	input  wire  [17:0] centroid,
	input  wire         centroid_valid,
	input  wire         golden_gate,
	input  wire         saturated,
	input  wire         end_check,
	output int          outstanding,
	output int          fail_count
);
	import sca_pkg::*;

	localparam int STRIP_MAX = 64;
	localparam int CHARGE_TOP = int'(CHARGE_MAX);
	localparam longint CENTROID_TOP = longint'(CENTROID_MAX);

	typedef struct packed {
		logic [6:0]  strips;
		logic [6:0]  seeds;
		logic [6:0]  hits;
		logic [6:0]  misses;
		logic [9:0]  peak_ch;
		logic [15:0] peak_sig;
		logic [21:0] charge;
		logic [17:0] centroid;
		logic        cen_ok;
		logic        gate;
		logic        sat;
	} summary_t;

	summary_t sums_due[$];
	int errors = 0;
	int due_count = 0;

	logic [4:0]  seed_k;
	logic [4:0]  hit_k;
	logic [9:0]  lim_reg;
	logic [11:0] sat_reg;

	int         n_strip, n_seed, n_hit, n_miss;
	int         charge;
	int         peak;
	logic [9:0] peak_at;
	int         prev_s;
	logic [9:0] prev_at;
	int         left_s, right_s;
	logic [9:0] left_at, right_at;
	bit         left_ok, right_ok, right_wait;
	logic [9:0] last_seed_at;
	bit         seed_seen, gap_flag, sat_flag;

	assign outstanding = due_count;
	assign fail_count = errors;

	task automatic flag_error(input string msg);
		errors++;
		$display("%0t sca_checker: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			flag_error($sformatf("%s is %0d, expected %0d", name, got, want));
	endtask

	function automatic bit exceeds(input int s, input logic [15:0] sigma, input logic [4:0] k);
		if (sigma == 0)
			return s > 0;
		return longint'(s) > longint'(k) * longint'(sigma);
	endfunction

	function automatic int bump(input int c);
		return (c < STRIP_MAX) ? c + 1 : c;
	endfunction

	task automatic clear_cluster();
		n_strip = 0;
		n_seed = 0;
		n_hit = 0;
		n_miss = 0;
		charge = 0;
		peak = 0;
		peak_at = '0;
		prev_s = 0;
		prev_at = '0;
		left_s = 0;
		left_at = '0;
		left_ok = 0;
		right_s = 0;
		right_at = '0;
		right_ok = 0;
		right_wait = 0;
		last_seed_at = '0;
		seed_seen = 0;
		gap_flag = 0;
		sat_flag = 0;
	endtask

	task automatic close_cluster();
		summary_t sum;
		int ls, rs, ns;
		logic [9:0] nch;
		longint den, num, q;
		sum = '0;
		if (peak > 0) begin
			ls = left_ok ? left_s : 0;
			rs = right_ok ? right_s : 0;
			if (ls < rs) begin
				ns = rs;
				nch = right_at;
			end else begin
				ns = ls;
				nch = left_ok ? left_at : '0;
			end
			den = longint'(peak) + longint'(ns);
			if (den > 0) begin
				sum.cen_ok = 1'b1;
				num = (longint'(peak_at) * peak + longint'(nch) * ns) * 256;
				if (num > 0) begin
					q = num / den;
					sum.centroid = (q > CENTROID_TOP) ? CENTROID_MAX : q[17:0];
				end
			end
			sum.peak_ch = peak_at;
			sum.peak_sig = peak[15:0];
		end
		sum.strips = 7'(n_strip);
		sum.seeds = 7'(n_seed);
		sum.hits = 7'(n_hit);
		sum.misses = 7'(n_miss);
		sum.charge = 22'(charge);
		sum.gate = gap_flag && n_strip >= 3;
		sum.sat = sat_flag;
		sums_due = {sums_due, sum};
		clear_cluster();
	endtask

	task automatic take_strip(input logic [9:0] ch, input logic [11:0] a, input logic [15:0] pm,
			input logic [15:0] ps, input logic fin);
		int s;
		bit seed, hit;
		if (ch <= lim_reg) begin
			s = 16 * int'(a) - int'(pm);
			seed = exceeds(s, ps, seed_k);
			hit = !seed && exceeds(s, ps, hit_k);
			if (seed)
				n_seed = bump(n_seed);
			else if (hit)
				n_hit = bump(n_hit);
			else
				n_miss = bump(n_miss);
			if (seed || hit) begin
				charge = charge + s;
				if (charge > CHARGE_TOP)
					charge = CHARGE_TOP;
				if (charge < 0)
					charge = 0;
			end
			if (a >= sat_reg)
				sat_flag = 1;
			if (seed) begin
				if (seed_seen && int'(last_seed_at) + 1 != int'(ch))
					gap_flag = 1;
				last_seed_at = ch;
				seed_seen = 1;
			end
			if (s > peak) begin
				peak = s;
				peak_at = ch;
				left_ok = n_strip > 0;
				left_s = left_ok ? prev_s : 0;
				left_at = left_ok ? prev_at : '0;
				right_ok = 0;
				right_s = 0;
				right_at = '0;
				right_wait = 1;
			end else if (right_wait) begin
				right_s = s;
				right_at = ch;
				right_ok = 1;
				right_wait = 0;
			end
			prev_s = s;
			prev_at = ch;
			n_strip = bump(n_strip);
		end
		if (fin)
			close_cluster();
	endtask

	always @(posedge clk or negedge arst_n) begin
		summary_t want;
		if (!arst_n) begin
			seed_k = SEED_SIGMA_RST;
			hit_k = HIT_SIGMA_RST;
			lim_reg = CHAN_LIMIT_RST;
			sat_reg = SAT_LEVEL_RST;
			clear_cluster();
			sums_due.delete();
			due_count <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (sums_due.size() == 0) begin
					flag_error("summary word arrived with none expected");
				end else begin
					want = sums_due.pop_front();
					check_field("strip_count", strip_count, want.strips);
					check_field("seed_count", seed_count, want.seeds);
					check_field("hit_count", hit_count, want.hits);
					check_field("miss_count", miss_count, want.misses);
					check_field("peak_channel", peak_channel, want.peak_ch);
					check_field("peak_signal", peak_signal, want.peak_sig);
					check_field("cluster_charge", cluster_charge, want.charge);
					check_field("centroid", centroid, want.centroid);
					check_field("centroid_valid", centroid_valid, want.cen_ok);
					check_field("golden_gate", golden_gate, want.gate);
					check_field("saturated", saturated, want.sat);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SEED_SIGMA: seed_k = cfg_data[4:0];
					REG_HIT_SIGMA:  hit_k = cfg_data[4:0];
					REG_CHAN_LIMIT: lim_reg = cfg_data[9:0];
					REG_SAT_LEVEL:  sat_reg = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				take_strip(channel, adc, ped_mean, ped_sigma, last_strip);
			if (end_check) begin
				repeat (sums_due.size())
					flag_error("expected summary word never arrived");
				sums_due.delete();
			end
			due_count <= sums_due.size();
		end
	end

endmodule

[tb/sv/tb_strip_cluster_accumulator.sv]
// testbench top for the strip cluster accumulator: clock, reset, register writes, directed
// and random strip clusters with random idling on both channels, final verdict
// depends on sca_pkg, strip_cluster_accumulator and sca_checker
module tb_strip_cluster_accumulator;
	import sca_pkg::*;

	localparam logic [3:0] REG_SPARE = 4'd12;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT = 400000;
	localparam int IDLE_PCT = 6;
	localparam int PHASE_ITEMS = 90;
	localparam int PHASES = 8;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [3:0]  cfg_index = '0;
	logic [11:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [9:0]  channel = '0;
	logic [11:0] adc = '0;
	logic [15:0] ped_mean = '0;
	logic [15:0] ped_sigma = '0;
	logic        last_strip = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [6:0]  strip_count, seed_count, hit_count, miss_count;
	logic [9:0]  peak_channel;
	logic [15:0] peak_signal;
	logic [21:0] cluster_charge;
	logic [17:0] centroid;
	logic        centroid_valid, golden_gate, saturated;

	logic        end_check = 1'b0;
	logic        quiet = 1'b0;
	int          outstanding, fail_count;
	int          cycles = 0;
	int          accepted_items, tried_items;
	logic [9:0]  cur_limit = CHAN_LIMIT_RST;

	strip_cluster_accumulator i_dut (.*);

	sca_checker i_checker (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk)
		out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);

	task automatic send_strip(input logic [9:0] ch, input logic [11:0] a, input logic [15:0] pm,
			input logic [15:0] ps, input logic fin);
		if (!quiet && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		channel <= ch;
		adc <= a;
		ped_mean <= pm;
		ped_sigma <= ps;
		last_strip <= fin;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic write_reg(input logic [3:0] idx, input logic [11:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic program_regs(input logic [4:0] seed, input logic [4:0] hit,
			input logic [9:0] lim, input logic [11:0] sat);
		write_reg(REG_SEED_SIGMA, 12'(seed));
		write_reg(REG_HIT_SIGMA, 12'(hit));
		write_reg(REG_CHAN_LIMIT, 12'(lim));
		write_reg(REG_SAT_LEVEL, sat);
		write_reg(REG_SPARE, 12'($urandom));
		cfg_valid <= 1'b0;
		cur_limit = lim;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_cluster();
		int len, pick, snr, level;
		logic [9:0] ch;
		logic [11:0] a;
		logic [15:0] pm, ps;
		len = ($urandom_range(99) < 3) ? $urandom_range(60, 70) : $urandom_range(1, 6);
		ch = 10'($urandom_range(0, cur_limit));
		for (int k = 0; k < len; k++) begin
			pick = $urandom_range(99);
			if (k > 0) begin
				if (pick < 5)
					ch = 10'($urandom);
				else if (pick < 10)
					ch = ch + 10'd2;
				else
					ch = ch + 10'd1;
			end
			case ($urandom_range(9))
				0: ps = '0;
				1: ps = 16'($urandom);
				default: ps = 16'($urandom_range(4, 600));
			endcase
			pm = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16000));
			snr = $urandom_range(0, 40);
			level = (int'(pm) + snr * int'(ps)) / 16 + $urandom_range(0, 1);
			a = (level > 4095) ? 12'd4095 : 12'(level);
			if (pick >= 95)
				a = 12'($urandom);
			send_strip(ch, a, pm, ps, k == len - 1);
			tried_items++;
			if (ch <= cur_limit)
				accepted_items++;
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// default registers: empty cluster, zero-sigma seed, zero-sigma miss
		send_strip(1023, 4095, 0, 0, 1);
		send_strip(0, 4095, 0, 0, 1);
		send_strip(1, 0, 65535, 0, 1);
		wait_idle();

		program_regs(5'd10, 5'd5, 10'd1023, SAT_LEVEL_RST);
		// separated seeds
		send_strip(10, 100, 0, 16, 0);
		send_strip(11, 10, 0, 16, 0);
		send_strip(12, 100, 0, 16, 1);
		// tied maximum, adjacent seeds
		send_strip(20, 200, 0, 16, 0);
		send_strip(21, 200, 0, 16, 0);
		send_strip(22, 50, 0, 16, 1);
		// extreme pedestal, negative signal
		send_strip(5, 4095, 65535, 65535, 1);
		// centroid above range
		send_strip(0, 0, 50, 0, 0);
		send_strip(1000, 4, 13, 0, 0);
		send_strip(1, 0, 99, 0, 1);
		// centroid below range
		send_strip(1023, 0, 50, 0, 0);
		send_strip(0, 4, 13, 0, 0);
		send_strip(2, 0, 99, 0, 1);
		// zero denominator
		send_strip(3, 0, 50, 0, 0);
		send_strip(4, 4, 14, 0, 0);
		send_strip(5, 0, 60, 0, 1);
		// right neighbour larger
		send_strip(30, 5, 0, 16, 0);
		send_strip(31, 100, 0, 16, 0);
		send_strip(32, 20, 0, 16, 1);
		wait_idle();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: program_regs(5'd31, 5'd31, 10'd1023, 12'd4095);
				1: program_regs(5'd0, 5'd0, 10'd0, 12'd0);
				2: program_regs(SEED_SIGMA_RST, HIT_SIGMA_RST, 10'd1023, SAT_LEVEL_RST);
				default: program_regs(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
						10'($urandom_range(64, 1023)), 12'($urandom_range(1500, 4095)));
			endcase
			quiet <= (p == 2);
			accepted_items = 0;
			tried_items = 0;
			while (accepted_items < PHASE_ITEMS && tried_items < PHASE_ITEMS + PHASE_ITEMS / 2)
				send_cluster();
			wait_idle();
		end

		end_check <= 1'b1;
		repeat (2) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

[strip_cluster_accumulator.f]
rtl/sca_pkg.sv
rtl/sca_cfg.sv
rtl/sca_ctrl.sv
rtl/sca_dp.sv
rtl/strip_cluster_accumulator.sv
tb/sv/sca_checker.sv
tb/sv/tb_strip_cluster_accumulator.sv
